// File: rtl/core/tstm_pkg.sv
package tstm_pkg;

  localparam int unsigned ModeBits   = 3;
  localparam int unsigned MachBits   = 4;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned SlotOutBits = 10;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned PeriodBits = 16;
  localparam int unsigned ActBits    = 3;

  typedef enum logic [ModeBits-1:0] {
    MODE_ADD_RULE = 3'd0,
    MODE_SET_INIT = 3'd1,
    MODE_CHECK    = 3'd2,
    MODE_COPY     = 3'd3,
    MODE_MOVE     = 3'd4,
    MODE_RESET    = 3'd5
  } mode_t;

  typedef enum logic [StatusBits-1:0] {
    ST_DONE      = 3'd0,
    ST_OK        = 3'd1,
    ST_NO_RULES  = 3'd2,
    ST_SILENT    = 3'd3,
    ST_LOGGED    = 3'd4,
    ST_ABORT     = 3'd5,
    ST_RULE_FULL = 3'd6
  } status_t;

  typedef enum logic [ActBits-1:0] {
    ACT_OFF          = 3'd0,
    ACT_LOG          = 3'd1,
    ACT_ABORT        = 3'd2,
    ACT_SAMPLE_ABORT = 3'd3,
    ACT_SAMPLE_LOG   = 3'd4
  } action_t;

  localparam logic [ActBits-1:0]    ActionReset = ACT_ABORT;
  localparam logic [PeriodBits-1:0] PeriodReset = 16'd1000;

  localparam int unsigned RegAction = 0;
  localparam int unsigned RegPeriod = 1;

  // Control from the sequencer to the sampling divider, and its answer.
  typedef struct packed {
    logic                  start;
    logic [CountBits-1:0]  dividend;
    logic [PeriodBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic zero_rem;
  } div_rsp_t;

endpackage

// File: rtl/core/tstm_if.sv
interface tstm_in_if #(
  parameter int unsigned STATE_BITS  = 16,
  parameter int unsigned METHOD_BITS = 16,
  parameter int unsigned KEY_BITS    = 64
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             mode;
  logic [3:0]             machine_id;
  logic [KEY_BITS-1:0]    object_key;
  logic [KEY_BITS-1:0]    other_key;
  logic [METHOD_BITS-1:0] method_id;
  logic [STATE_BITS-1:0]  from_state;
  logic [STATE_BITS-1:0]  to_state;

  modport source(output valid, mode, machine_id, object_key, other_key, method_id,
                 from_state, to_state, input ready);
  modport sink(input valid, mode, machine_id, object_key, other_key, method_id,
               from_state, to_state, output ready);
endinterface

interface tstm_out_if #(
  parameter int unsigned STATE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [STATE_BITS-1:0] state_before;
  logic [STATE_BITS-1:0] state_after;
  logic [9:0]            object_slot;

  modport source(output valid, status, state_before, state_after, object_slot,
                 input ready);
  modport sink(input valid, status, state_before, state_after, object_slot,
               output ready);
endinterface

// File: rtl/core/tstm_div.sv
module tstm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  tstm_pkg::div_req_t          req,
  output tstm_pkg::div_rsp_t          rsp
);
  import tstm_pkg::*;

  // Restoring divider, one quotient bit per cycle; only the remainder is kept.
  logic [CountBits-1:0]    num;
  logic [PeriodBits:0]     rem;
  logic [PeriodBits-1:0]   den;
  logic [5:0]              cnt;
  logic                    busy;
  logic [PeriodBits:0]     shifted;

  always_comb begin
    shifted = {rem[PeriodBits-1:0], num[CountBits-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'(CountBits);
      num  <= req.dividend;
      den  <= req.divisor;
      rem  <= '0;
    end else if (busy) begin
      num <= {num[CountBits-2:0], 1'b0};
      if (shifted >= {1'b0, den}) rem <= shifted - {1'b0, den};
      else                        rem <= shifted;
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign rsp.busy     = busy | req.start;
  assign rsp.zero_rem = (rem == '0);
endmodule

// File: rtl/core/tstm_apb.sv
module tstm_apb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [tstm_pkg::ActBits-1:0]   violation_action,
  output logic [tstm_pkg::PeriodBits-1:0] sample_period
);
  import tstm_pkg::*;

  logic wr;
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      violation_action <= ActionReset;
      sample_period    <= PeriodReset;
    end else if (wr) begin
      if (paddr[2] == 1'(RegAction)) violation_action <= pwdata[ActBits-1:0];
      else                           sample_period    <= pwdata[PeriodBits-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == 1'(RegAction)) prdata = {29'd0, violation_action};
    else                           prdata = {16'd0, sample_period};
  end
endmodule

// File: rtl/core/typestate_transition_monitor_core.sv
// Channel  | Direction | Words
// in       | sink      | one command word per item
// out      | source    | one result word per item
// cfg      | APB       | violation_action @0x0, sample_period @0x4
// One item at a time, and the input is not ready until the result is taken.
// Each table scan reads one memory entry per cycle: an object lookup scans the
// object table (done twice for copy and move), a check adds a rule scan for
// the match and, when the start state is inferred, a nested rule scan. A
// sampled violation adds a division for the remainder.
// Synchronous active-high reset clears counts and control; memories are not
// cleared. A result waits in the output register until taken.
module typestate_transition_monitor_core #(
  parameter int unsigned RULE_SLOTS   = 1024,
  parameter int unsigned OBJECT_SLOTS = 1024,
  parameter int unsigned MACHINES     = 16,
  parameter int unsigned STATE_BITS   = 16,
  parameter int unsigned METHOD_BITS  = 16,
  parameter int unsigned KEY_BITS     = 64
) (
  input  logic        clk,
  input  logic        rst,
  tstm_in_if.sink     in_ch,
  tstm_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tstm_pkg::*;

  localparam int unsigned RA = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned OA = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
  localparam int unsigned RC = $clog2(RULE_SLOTS + 1);
  localparam int unsigned OC = $clog2(OBJECT_SLOTS + 1);
  localparam int unsigned RW = 2 * STATE_BITS + METHOD_BITS + MachBits;
  localparam int unsigned EW = STATE_BITS + MachBits;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_OBJ    = 13'b0000000000010,  // search object table
    S_OBJW   = 13'b0000000000100,  // lookup result settled
    S_STATE  = 13'b0000000001000,  // read object entry
    S_INF_I  = 13'b0000000010000,  // inference outer read
    S_INF_J  = 13'b0000000100000,  // inference inner scan
    S_MATCH  = 13'b0000001000000,  // scan rules for transition
    S_VIOL   = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_FIN    = 13'b0001000000000,
    S_CPY    = 13'b0010000000000,  // read source state
    S_WRITE  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t st;

  logic [ActBits-1:0]    violation_action;
  logic [PeriodBits-1:0] sample_period;

  tstm_apb u_apb (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .violation_action, .sample_period
  );

  // Memories with registered reads.
  logic [RW-1:0]       rule_mem [RULE_SLOTS];
  logic [KEY_BITS-1:0] key_mem  [OBJECT_SLOTS];
  logic [EW-1:0]       ent_mem  [OBJECT_SLOTS];
  logic [RW-1:0]       rule_rd;
  logic [KEY_BITS-1:0] key_rd;
  logic [EW-1:0]       ent_rd;
  logic [RA-1:0]       rule_ra;
  logic [OA-1:0]       obj_ra;
  logic                rule_we, key_we, ent_we;
  logic [RA-1:0]       rule_wa;
  logic [OA-1:0]       obj_wa;
  logic [RW-1:0]       rule_wd;
  logic [KEY_BITS-1:0] key_wd;
  logic [EW-1:0]       ent_wd;

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    rule_rd <= rule_mem[rule_ra];
  end
  always_ff @(posedge clk) begin
    if (key_we) key_mem[obj_wa] <= key_wd;
    key_rd <= key_mem[obj_ra];
  end
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[obj_wa] <= ent_wd;
    ent_rd <= ent_mem[obj_ra];
  end

  // Rule field unpacking: {machine, from, method, to}.
  logic [MachBits-1:0]    r_mach;
  logic [STATE_BITS-1:0]  r_from, r_to;
  logic [METHOD_BITS-1:0] r_meth;
  assign {r_mach, r_from, r_meth, r_to} = rule_rd;

  // Captured item.
  logic [ModeBits-1:0]    mode;
  logic [MachBits-1:0]    mach;
  logic [KEY_BITS-1:0]    key, other;
  logic [METHOD_BITS-1:0] meth;
  logic [STATE_BITS-1:0]  to_in;

  logic [RC-1:0]  rule_count;
  logic [OC-1:0]  object_count;
  logic [STATE_BITS-1:0] init_val [MACHINES];
  logic [MACHINES-1:0]   init_vld;
  logic [CountBits-1:0]  violation_count;

  logic [RC-1:0] ri, rj;        // rule scan pointers
  logic [OC-1:0] oi;            // object scan pointer
  logic          rvalid;        // rule_rd holds entry of previous pointer
  logic          ovalid;
  logic          phase;         // copy/move: 0 source lookup, 1 destination
  logic [OA-1:0] src_slot, slot;
  logic [MachBits-1:0]   slot_mach;  // machine field kept in the slot's entry
  logic [STATE_BITS-1:0] prior, after, cand, pick;
  logic [StatusBits-1:0] status;

  div_req_t dreq;
  div_rsp_t drsp;
  tstm_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  logic [RA-1:0] ri_a, rj_a;
  logic [OA-1:0] oi_a, last_slot;
  assign ri_a = ri[RA-1:0];
  assign rj_a = rj[RA-1:0];
  assign oi_a = oi[OA-1:0];
  assign last_slot = OA'(OBJECT_SLOTS - 1);

  logic [KEY_BITS-1:0] look_key;
  assign look_key = (phase == 1'b0 && (mode == MODE_COPY || mode == MODE_MOVE)) ?
                    other : key;

  assign in_ch.ready = (st == S_IDLE);

  // Read address selection.
  always_comb begin
    rule_ra = ri_a;
    if (st == S_INF_J) rule_ra = rj_a;
    obj_ra = oi_a;
    if (st == S_STATE || st == S_WRITE || st == S_OBJW) obj_ra = slot;
    if (st == S_CPY || (st == S_STATE && (mode == MODE_COPY || mode == MODE_MOVE)))
      obj_ra = src_slot;
  end

  always_ff @(posedge clk) begin
    rule_we <= 1'b0;
    key_we  <= 1'b0;
    ent_we  <= 1'b0;
    dreq.start <= 1'b0;
    if (rst) begin
      st <= S_IDLE;
      rule_count <= '0;
      object_count <= '0;
      init_vld <= '0;
      violation_count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: if (in_ch.valid) begin
          mode  <= in_ch.mode;
          mach  <= in_ch.machine_id;
          key   <= in_ch.object_key;
          other <= in_ch.other_key;
          meth  <= in_ch.method_id;
          to_in <= in_ch.to_state;
          prior <= '0; after <= '0; slot <= '0;
          status <= ST_DONE;
          phase <= 1'b0;
          oi <= '0; ri <= '0; ovalid <= 1'b0; rvalid <= 1'b0;
          st <= S_OUT;
          case (in_ch.mode)
            MODE_ADD_RULE: if (32'(in_ch.machine_id) < MACHINES) begin
              if (32'(rule_count) >= RULE_SLOTS) status <= ST_RULE_FULL;
              else begin
                rule_we <= 1'b1;
                rule_wa <= rule_count[RA-1:0];
                rule_wd <= {in_ch.machine_id, in_ch.from_state, in_ch.method_id,
                            in_ch.to_state};
                rule_count <= rule_count + RC'(1);
              end
            end
            MODE_SET_INIT: if (32'(in_ch.machine_id) < MACHINES) begin
              init_val[in_ch.machine_id] <= in_ch.to_state;
              init_vld[in_ch.machine_id] <= 1'b1;
            end
            MODE_CHECK: if (32'(in_ch.machine_id) < MACHINES) begin
              if (rule_count == '0) status <= ST_NO_RULES;
              else st <= S_OBJ;
            end
            MODE_COPY, MODE_MOVE, MODE_RESET: st <= S_OBJ;
            default: ;
          endcase
        end
        S_OBJ: begin
          // One object entry per cycle; data for oi-1 arrives now.
          if (ovalid && key_rd == look_key && ent_rd[EW-1 -: MachBits] == mach) begin
            slot <= oi_a - OA'(1);
            st <= S_OBJW;
          end else if (oi == object_count || 32'(oi) >= OBJECT_SLOTS) begin
            if (32'(object_count) < OBJECT_SLOTS) begin
              slot <= object_count[OA-1:0];
              key_we <= 1'b1; ent_we <= 1'b1;
              obj_wa <= object_count[OA-1:0];
              key_wd <= look_key;
              ent_wd <= {mach, {STATE_BITS{1'b0}}};
              object_count <= object_count + OC'(1);
            end else slot <= last_slot;
            st <= S_OBJW;
          end else begin
            oi <= oi + OC'(1);
            ovalid <= 1'b1;
          end
        end
        S_OBJW: begin
          if ((mode == MODE_COPY || mode == MODE_MOVE) && !phase) begin
            src_slot <= slot;
            phase <= 1'b1;
            oi <= '0; ovalid <= 1'b0;
            st <= S_OBJ;
          end else if (ent_we) begin
            // A new entry is written at the end of this cycle; read it again.
            st <= S_OBJW;
          end else st <= S_STATE;
        end
        S_STATE: begin
          // ent_rd now holds the entry at slot (read issued in S_OBJW).
          prior <= ent_rd[STATE_BITS-1:0];
          slot_mach <= ent_rd[EW-1 -: MachBits];
          if (mode == MODE_RESET) begin
            after <= '0;
            ent_we <= 1'b1; obj_wa <= slot;
            ent_wd <= {ent_rd[EW-1 -: MachBits], {STATE_BITS{1'b0}}};
            st <= S_OUT;
          end else if (mode == MODE_COPY || mode == MODE_MOVE) begin
            st <= S_CPY;
          end else if (ent_rd[STATE_BITS-1:0] != '0) begin
            ri <= '0; rvalid <= 1'b0; st <= S_MATCH;
          end else if (init_vld[mach]) begin
            prior <= init_val[mach];
            ri <= '0; rvalid <= 1'b0; st <= S_MATCH;
          end else begin
            pick <= '0; ri <= '0; rvalid <= 1'b0; st <= S_INF_I;
          end
        end
        S_INF_I: begin
          if (rvalid && r_mach == mach) begin
            cand <= r_from;
            rj <= '0; rvalid <= 1'b0;
            st <= S_INF_J;
          end else if (ri == rule_count) begin
            prior <= pick;
            ri <= '0; rvalid <= 1'b0; st <= S_MATCH;
          end else begin
            ri <= ri + RC'(1); rvalid <= 1'b1;
          end
        end
        S_INF_J: begin
          if (rvalid && r_mach == mach && r_to == cand) begin
            if (pick == '0) pick <= cand;
            // ri already points past the candidate, so the outer scan resumes there.
            rvalid <= 1'b0;
            st <= S_INF_I;
          end else if (rj == rule_count) begin
            prior <= cand;
            ri <= '0; rvalid <= 1'b0; st <= S_MATCH;
          end else begin
            rj <= rj + RC'(1); rvalid <= 1'b1;
          end
        end
        S_MATCH: begin
          if (rvalid && r_mach == mach && r_from == prior && r_meth == meth) begin
            after <= r_to; status <= ST_OK;
            ent_we <= 1'b1; obj_wa <= slot; ent_wd <= {slot_mach, r_to};
            st <= S_OUT;
          end else if (ri == rule_count) begin
            after <= prior;
            ent_we <= 1'b1; obj_wa <= slot; ent_wd <= {slot_mach, prior};
            violation_count <= violation_count + 32'd1;
            st <= S_VIOL;
          end else begin
            ri <= ri + RC'(1); rvalid <= 1'b1;
          end
        end
        S_VIOL: begin
          if ((violation_action == ACT_SAMPLE_ABORT || violation_action == ACT_SAMPLE_LOG)
              && sample_period > 16'd1) begin
            dreq.start <= 1'b1;
            dreq.dividend <= violation_count;
            dreq.divisor <= sample_period;
            st <= S_DIV;
          end else begin
            if (violation_action == ACT_OFF) status <= ST_SILENT;
            else if (violation_action == ACT_LOG || violation_action == ACT_SAMPLE_LOG)
              status <= ST_LOGGED;
            else status <= ST_ABORT;
            st <= S_OUT;
          end
        end
        S_DIV: if (!drsp.busy) st <= S_FIN;
        S_FIN: begin
          if (!drsp.zero_rem) status <= ST_SILENT;
          else if (violation_action == ACT_SAMPLE_LOG) status <= ST_LOGGED;
          else status <= ST_ABORT;
          st <= S_OUT;
        end
        S_CPY: begin
          // ent_rd holds the source entry.
          ent_we <= 1'b1; obj_wa <= slot;
          ent_wd <= {slot_mach, ent_rd[STATE_BITS-1:0]};
          after <= ent_rd[STATE_BITS-1:0];
          st <= (mode == MODE_MOVE) ? S_WRITE : S_OUT;
        end
        S_WRITE: begin
          // ent_rd still holds the source entry, read in S_CPY.
          ent_we <= 1'b1; obj_wa <= src_slot;
          ent_wd <= {ent_rd[EW-1 -: MachBits], {STATE_BITS{1'b0}}};
          if (src_slot == slot) after <= '0;
          st <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.status <= status;
            out_ch.state_before <= prior;
            out_ch.state_after <= after;
            out_ch.object_slot <= 10'(slot);
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_rules_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rule_count) <= RULE_SLOTS) else $error("rule count overflow");
  a_objs_bound: assert property (@(posedge clk) disable iff (rst)
    32'(object_count) <= OBJECT_SLOTS) else $error("object count overflow");
`endif
endmodule
